[hdl/tpo_pkg.sv]
// Shared constants for the triangle pair overlap (separating axis) core.
// No dependencies; imported by tpo_axis_test and triangle_pair_overlap_sat_core.
package tpo_pkg;

	// vertices per triangle
	localparam int NUM_VERTS = 3;
	// candidate axes: one edge normal per edge of each triangle
	localparam int NUM_AXES = 2 * NUM_VERTS;
	// cycles from the axis unit's inputs to its separation flag
	localparam int AXIS_LAT = 5;

endpackage

[hdl/triangle_pair_overlap_sat_core.sv]
// Top level of the 2D triangle pair overlap core (separating axis test).
// Depends on tpo_pkg and tpo_axis_test.
//
// Pulse start with two triangles (Q.8 signed coordinates) to transfer a pair;
// busy stays low, so a new pair is taken every cycle. At the end of the
// pipeline below, done is high for one cycle with overlap valid (1 = no
// separating axis, touching counts as overlap). Results cannot be held off
// and are delivered in order. Stages: input and edge-normal register, axis
// products, dot-product sums, a two-stage min/max, the gap compare per axis,
// and output register. Six axis units run in parallel, one per edge normal.
module triangle_pair_overlap_sat_core #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] a_x0,
	input  logic signed [COORD_BITS-1:0] a_y0,
	input  logic signed [COORD_BITS-1:0] a_x1,
	input  logic signed [COORD_BITS-1:0] a_y1,
	input  logic signed [COORD_BITS-1:0] a_x2,
	input  logic signed [COORD_BITS-1:0] a_y2,
	input  logic signed [COORD_BITS-1:0] b_x0,
	input  logic signed [COORD_BITS-1:0] b_y0,
	input  logic signed [COORD_BITS-1:0] b_x1,
	input  logic signed [COORD_BITS-1:0] b_y1,
	input  logic signed [COORD_BITS-1:0] b_x2,
	input  logic signed [COORD_BITS-1:0] b_y2,
	output logic                         done,
	output logic                         overlap
);
	import tpo_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int NV = 2 * NUM_VERTS;

	logic signed [W-1:0] vx [NV];
	logic signed [W-1:0] vy [NV];
	logic signed [W-1:0] vx_s1 [NV];
	logic signed [W-1:0] vy_s1 [NV];
	logic signed [W:0]   axis_x_s1 [NUM_AXES];
	logic signed [W:0]   axis_y_s1 [NUM_AXES];
	logic [NUM_AXES-1:0] sep_s6;
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                done_s7;
	logic                overlap_s7;
	logic                accept;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// vertices 0..2 of A, then 0..2 of B
	assign vx = '{a_x0, a_x1, a_x2, b_x0, b_x1, b_x2};
	assign vy = '{a_y0, a_y1, a_y2, b_y0, b_y1, b_y2};

	// input register
	always_ff @(posedge clk) begin
		vx_s1 <= vx;
		vy_s1 <= vy;
	end

	// edge normals: edge i -> next, axis = (y_i - y_next, x_next - x_i)
	for (genvar e = 0; e < NUM_AXES; e++) begin : g_axis
		localparam int T = e / NUM_VERTS;
		localparam int I = T * NUM_VERTS + (e % NUM_VERTS);
		localparam int N = T * NUM_VERTS + ((e % NUM_VERTS) + 1) % NUM_VERTS;

		always_ff @(posedge clk) begin
			axis_x_s1[e] <= (W+1)'(vy[I]) - (W+1)'(vy[N]);
			axis_y_s1[e] <= (W+1)'(vx[N]) - (W+1)'(vx[I]);
		end

		tpo_axis_test #(
			.COORD_BITS(COORD_BITS)
		) u_axis (
			.clk   (clk),
			.px    (vx_s1),
			.py    (vy_s1),
			.axis_x(axis_x_s1[e]),
			.axis_y(axis_y_s1[e]),
			.sep   (sep_s6[e])
		);
	end

	// valid bits follow the data through the axis units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			done_s7 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			done_s7 <= vld_s6;
		end
	end

	// overlap unless some axis separates
	always_ff @(posedge clk) begin
		overlap_s7 <= ~|sep_s6;
	end

	assign done    = done_s7;
	assign overlap = overlap_s7;

`ifndef SYNTHESIS
	// every result comes from a transfer that has passed the full pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, AXIS_LAT + 2))
		else $error("result without matching transfer");

	// every transfer yields a result
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 done)
		else $error("transfer lost in pipeline");

	// identical triangles always overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && a_x0 == b_x0 && a_y0 == b_y0 && a_x1 == b_x1 && a_y1 == b_y1
		&& a_x2 == b_x2 && a_y2 == b_y2 |-> ##7 overlap)
		else $error("identical triangles reported separated");
`endif

endmodule

[hdl/tpo_axis_test.sv]
// One candidate axis: projects both triangles and flags a strict gap between them.
// Depends on tpo_pkg. Registered pipeline from products to gap flag, no stall.
module tpo_axis_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic signed [COORD_BITS-1:0] px [2*tpo_pkg::NUM_VERTS],
	input  logic signed [COORD_BITS-1:0] py [2*tpo_pkg::NUM_VERTS],
	input  logic signed [COORD_BITS:0]   axis_x,
	input  logic signed [COORD_BITS:0]   axis_y,
	output logic                         sep
);
	import tpo_pkg::*;

	localparam int PW = 2 * COORD_BITS + 1;   // one product
	localparam int SW = 2 * COORD_BITS + 2;   // sum of two products
	localparam int NV = 2 * NUM_VERTS;

	logic signed [PW-1:0] prod_x_s2 [NV];
	logic signed [PW-1:0] prod_y_s2 [NV];
	logic signed [SW-1:0] proj_s3 [NV];
	logic signed [SW-1:0] mn01_s4 [2];
	logic signed [SW-1:0] mx01_s4 [2];
	logic signed [SW-1:0] p2_s4 [2];
	logic signed [SW-1:0] mn_s5 [2];
	logic signed [SW-1:0] mx_s5 [2];
	logic                 sep_s6;

	// products of every vertex coordinate with the axis components
	always_ff @(posedge clk) begin
		for (int k = 0; k < NV; k++) begin
			prod_x_s2[k] <= PW'(px[k]) * PW'(axis_x);
			prod_y_s2[k] <= PW'(py[k]) * PW'(axis_y);
		end
	end

	// dot products
	always_ff @(posedge clk) begin
		for (int k = 0; k < NV; k++) begin
			proj_s3[k] <= SW'(prod_x_s2[k]) + SW'(prod_y_s2[k]);
		end
	end

	// min/max per triangle, split over two stages
	for (genvar t = 0; t < 2; t++) begin : g_tri
		localparam int B = t * NUM_VERTS;

		always_ff @(posedge clk) begin
			mn01_s4[t] <= (proj_s3[B+1] < proj_s3[B]) ? proj_s3[B+1] : proj_s3[B];
			mx01_s4[t] <= (proj_s3[B] < proj_s3[B+1]) ? proj_s3[B+1] : proj_s3[B];
			p2_s4[t]   <= proj_s3[B+2];
		end

		always_ff @(posedge clk) begin
			mn_s5[t] <= (p2_s4[t] < mn01_s4[t]) ? p2_s4[t] : mn01_s4[t];
			mx_s5[t] <= (mx01_s4[t] < p2_s4[t]) ? p2_s4[t] : mx01_s4[t];
		end
	end

	// strict gap on this axis; touching is overlap
	always_ff @(posedge clk) begin
		sep_s6 <= (mx_s5[0] < mn_s5[1]) || (mx_s5[1] < mn_s5[0]);
	end

	assign sep = sep_s6;

endmodule
